[design/fkt_pkg.sv]
// shared types and constants of the free-slot tracker
`default_nettype none

package fkt_pkg;

	// tree size
	localparam int LOG_SLOTS = 15;
	localparam int SLOTS     = 1 << LOG_SLOTS;
	localparam int ADDR_W    = LOG_SLOTS;
	localparam int NODE_W    = LOG_SLOTS + 1;
	localparam int CNT_W     = NODE_W;
	localparam int MEM_W     = CNT_W + 1;

	// request and result field widths
	localparam int FIELD_W = 16;
	localparam int EXT_W   = (NODE_W > FIELD_W) ? NODE_W : FIELD_W;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_MARK  = 2'd1,
		KIND_COUNT = 2'd2,
		KIND_FIND  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [FIELD_W-1:0]  slot_index;
		logic [FIELD_W-1:0]  rank;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] value;
		logic               found;
		logic               error;
	} rsp_t;

	// shared add / subtract unit
	typedef struct packed {
		logic [EXT_W-1:0] a;
		logic [EXT_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [EXT_W-1:0] res;
		logic             b_lt_a;
	} alu_rsp_t;

endpackage

`default_nettype wire

[design/fenwick_kth_free_slot_tracker.sv]
// top level of the fenwick free-slot tracker with its tree memory and sequencer
//
// tracks which of SLOTS = 2^LOG_SLOTS slots (numbered from one) are free, in a
// binary indexed tree kept in one single-port-write, registered-read memory
// request channel: req_valid / req_ready with req (kind, slot_index, rank)
// result channel: rsp_valid / rsp_ready with rsp (value, found, error)
// every request gives exactly one result, in request order
// one request is worked at a time; req_ready is high only while the sequencer
// is idle, and each tree level is a memory read, then an update through the
// shared add/subtract unit:
//   count: one level per set bit of the clamped index, at most LOG_SLOTS
//   mark:  one level per node of the update path, at most LOG_SLOTS+1
//   find:  a root check, then LOG_SLOTS+1 levels, no update past the tree
//   clear: a sweep over all SLOTS addresses, rewriting every tree node
// plus a step in the done state to hand the result to the output register
// after reset the same sweep runs before the first request is taken
// the result sits in an output register; a new request may be taken while it
// waits, and a finished request holds in the done state until the register
// frees up, so a stalled receiver stalls the block without losing anything
`default_nettype none

module fenwick_kth_free_slot_tracker
	import fkt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  req_t      req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	typedef enum logic [9:0] {
		ST_SWEEP    = 10'b00_0000_0001,
		ST_IDLE     = 10'b00_0000_0010,
		ST_CNT_RD   = 10'b00_0000_0100,
		ST_CNT_ACC  = 10'b00_0000_1000,
		ST_MARK_RD  = 10'b00_0001_0000,
		ST_MARK_UPD = 10'b00_0010_0000,
		ST_FIND_TOP = 10'b00_0100_0000,
		ST_FIND_RD  = 10'b00_1000_0000,
		ST_FIND_CMP = 10'b01_0000_0000,
		ST_DONE     = 10'b10_0000_0000
	} state_t;

	// sequencer state
	state_t            state_q;
	logic [NODE_W-1:0] idx_q;        // node index; sweep address in its low bits
	logic [NODE_W-1:0] pos_q;        // find descent position
	logic [NODE_W-1:0] step_q;       // find descent step, one-hot
	logic [EXT_W-1:0]  acc_q;        // running sum for count, remaining rank for find
	logic              first_q;      // first node of a mark walk
	logic              sweep_rsp_q;  // sweep was started by a clear request
	rsp_t              res_q;        // result waiting for the output register

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// tree memory: word holds the used bit of slot i and tree node i, node
	// SLOTS lives at address zero
	logic [MEM_W-1:0]  tree_mem_q [SLOTS];
	logic [MEM_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0] mem_raddr;
	logic [ADDR_W-1:0] mem_waddr;
	logic [MEM_W-1:0]  mem_wdata;
	logic              mem_we;

	// shared arithmetic unit
	alu_req_t alu_op;
	alu_rsp_t alu_res;

	// helpers
	logic [CNT_W-1:0]  rd_tree;
	logic              rd_used;
	logic [NODE_W-1:0] sweep_node;
	logic [NODE_W-1:0] sweep_low;
	logic [NODE_W-1:0] idx_low;
	logic [NODE_W:0]   mark_next;
	logic [NODE_W-1:0] cnt_next;
	logic [NODE_W-1:0] find_nxt;
	logic [NODE_W-1:0] find_pos_nx;
	logic [NODE_W-1:0] find_pos_inc;
	logic [EXT_W-1:0]  req_idx_ext;
	logic              rsp_free;
	logic              req_fire;

	assign rd_tree = rd_data_q[CNT_W-1:0];
	assign rd_used = rd_data_q[CNT_W];

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_idx_ext = EXT_W'(req.slot_index);

	// clearing pass: node at address zero is node SLOTS
	assign sweep_node = (idx_q[ADDR_W-1:0] == '0) ? NODE_W'(SLOTS)
	                                              : NODE_W'(idx_q[ADDR_W-1:0]);
	assign sweep_low  = sweep_node & (~sweep_node + NODE_W'(1));

	// index stepping of the tree walks
	assign idx_low   = idx_q & (~idx_q + NODE_W'(1));
	assign mark_next = {1'b0, idx_q} + {1'b0, idx_low};
	assign cnt_next  = idx_q & (idx_q - NODE_W'(1));

	// find descent
	assign find_nxt     = pos_q | step_q;
	assign find_pos_nx  = alu_res.b_lt_a ? find_nxt : pos_q;
	assign find_pos_inc = find_pos_nx + NODE_W'(1);

	// operand selection for the shared unit
	always_comb begin
		alu_op.a   = acc_q;
		alu_op.b   = EXT_W'(rd_tree);
		alu_op.sub = 1'b0;
		case (state_q)
			ST_FIND_TOP, ST_FIND_CMP: begin
				alu_op.sub = 1'b1;
			end
			ST_MARK_UPD: begin
				alu_op.a   = EXT_W'(rd_tree);
				alu_op.b   = EXT_W'(1);
				alu_op.sub = 1'b1;
			end
			default: begin
				alu_op.sub = 1'b0;
			end
		endcase
	end

	fkt_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// memory addressing
	always_comb begin
		mem_raddr = idx_q[ADDR_W-1:0];
		mem_waddr = idx_q[ADDR_W-1:0];
		mem_wdata = {1'b0, CNT_W'(sweep_low)};
		mem_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// root node, ready for a find
				mem_raddr = '0;
			end
			ST_FIND_RD: begin
				mem_raddr = find_nxt[ADDR_W-1:0];
			end
			ST_SWEEP: begin
				mem_we = 1'b1;
			end
			ST_MARK_UPD: begin
				mem_we    = !(first_q && rd_used);
				mem_wdata = {first_q | rd_used, alu_res.res[CNT_W-1:0]};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= tree_mem_q[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			idx_q       <= '0;
			sweep_rsp_q <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					idx_q <= idx_q + NODE_W'(1);
					if (idx_q[ADDR_W-1:0] == {ADDR_W{1'b1}}) begin
						state_q     <= sweep_rsp_q ? ST_DONE : ST_IDLE;
						sweep_rsp_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						case (req.kind)
							KIND_CLEAR: begin
								idx_q       <= '0;
								sweep_rsp_q <= 1'b1;
								state_q     <= ST_SWEEP;
							end
							KIND_MARK: begin
								idx_q   <= NODE_W'(req.slot_index);
								first_q <= 1'b1;
								if (req.slot_index == '0 || req_idx_ext > EXT_W'(SLOTS)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_MARK_RD;
								end
							end
							KIND_COUNT: begin
								// indexes beyond the tree clamp to the root
								if (req_idx_ext > EXT_W'(SLOTS)) begin
									idx_q <= NODE_W'(SLOTS);
								end else begin
									idx_q <= NODE_W'(req.slot_index);
								end
								state_q <= (req.slot_index == '0) ? ST_DONE : ST_CNT_RD;
							end
							KIND_FIND: begin
								state_q <= (req.rank == '0) ? ST_DONE : ST_FIND_TOP;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT_ACC;
				end
				ST_CNT_ACC: begin
					idx_q   <= cnt_next;
					state_q <= (cnt_next == '0) ? ST_DONE : ST_CNT_RD;
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_UPD;
				end
				ST_MARK_UPD: begin
					first_q <= 1'b0;
					idx_q   <= mark_next[NODE_W-1:0];
					if ((first_q && rd_used) || mark_next > (NODE_W+1)'(SLOTS)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MARK_RD;
					end
				end
				ST_FIND_TOP: begin
					// rank above the total free count fails at once
					state_q <= alu_res.b_lt_a ? ST_DONE : ST_FIND_RD;
				end
				ST_FIND_RD: begin
					if (find_nxt > NODE_W'(SLOTS)) begin
						state_q <= (step_q == NODE_W'(1)) ? ST_DONE : ST_FIND_RD;
					end else begin
						state_q <= ST_FIND_CMP;
					end
				end
				ST_FIND_CMP: begin
					state_q <= (step_q == NODE_W'(1)) ? ST_DONE : ST_FIND_RD;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers and the pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					acc_q <= (req.kind == KIND_FIND) ? EXT_W'(req.rank) : '0;
					// out-of-range marks are refused right away
					res_q <= '{value: '0, found: 1'b0,
					           error: (req.kind == KIND_MARK) &&
					                  (req.slot_index == '0 ||
					                   req_idx_ext > EXT_W'(SLOTS))};
				end
			end
			ST_CNT_ACC: begin
				acc_q <= alu_res.res;
				if (cnt_next == '0) begin
					res_q.value <= FIELD_W'(alu_res.res);
				end
			end
			ST_MARK_UPD: begin
				if (first_q && rd_used) begin
					res_q.error <= 1'b1;
				end
			end
			ST_FIND_TOP: begin
				pos_q  <= '0;
				step_q <= NODE_W'(SLOTS);
			end
			ST_FIND_RD: begin
				if (find_nxt > NODE_W'(SLOTS)) begin
					step_q <= step_q >> 1;
					if (step_q == NODE_W'(1)) begin
						res_q.value <= FIELD_W'(pos_q + NODE_W'(1));
						res_q.found <= 1'b1;
					end
				end
			end
			ST_FIND_CMP: begin
				step_q <= step_q >> 1;
				pos_q  <= find_pos_nx;
				if (alu_res.b_lt_a) begin
					acc_q <= alu_res.res;
				end
				if (step_q == NODE_W'(1)) begin
					res_q.value <= FIELD_W'(find_pos_inc);
					res_q.found <= 1'b1;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	// checks

	// a taken request drops req_ready in the following cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another was in flight");

	// every node on a mark walk still counts the slot being taken
	a_mark_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MARK_UPD && !(first_q && rd_used) |-> rd_tree != '0)
		else $error("mark walk decremented an empty tree node");

	// descent step stays a single bit
	a_find_step_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIND_RD || state_q == ST_FIND_CMP |-> $onehot(step_q))
		else $error("find step lost its single bit");

	// a found slot is never zero and never carries an error
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.found |-> !rsp_q.error && rsp_q.value != '0)
		else $error("found result with error or zero slot");

	// a refused mark reports nothing else
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.error |-> !rsp_q.found && rsp_q.value == '0)
		else $error("error result carries a value");

endmodule

`default_nettype wire

[design/fkt_alu.sv]
// shared adder, subtractor and comparator of the tracker
`default_nettype none

module fkt_alu
	import fkt_pkg::*;
(
	input  alu_req_t op,
	output alu_rsp_t res
);

	logic [EXT_W:0] sum;

	always_comb begin
		if (op.sub) begin
			sum = {1'b0, op.a} - {1'b0, op.b};
		end else begin
			sum = {1'b0, op.a} + {1'b0, op.b};
		end
		res.res    = sum[EXT_W-1:0];
		// b < a exactly when a - b neither borrows nor is zero
		res.b_lt_a = op.sub && !sum[EXT_W] && (sum[EXT_W-1:0] != '0);
	end

endmodule

`default_nettype wire
